// ----- src/knn_pkg.sv -----
// Shared types and constants for the k-nearest-neighbor selector.
package knn_pkg;

	localparam int MAX_DIMS  = 16;
	localparam int MAX_K     = 16;
	localparam int DIST_BITS = 38;
	localparam int ROOT_BITS = 19;

	localparam logic [1:0] KIND_QUERY  = 2'd0;
	localparam logic [1:0] KIND_TRAIN  = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	localparam logic [0:0] REG_DIMS = 1'b0;
	localparam logic [0:0] REG_K    = 1'b1;

	localparam logic [DIST_BITS-1:0] DIST_ONES   = {DIST_BITS{1'b1}};
	localparam logic [DIST_BITS-1:0] DIST_MAXFIN = {{(DIST_BITS-1){1'b1}}, 1'b0};

	typedef struct packed {
		logic [1:0]  kind;
		logic signed [15:0] coordinate;
	} in_item_t;

	typedef struct packed {
		logic [15:0] neighbour_index;
		logic        neighbour_valid;
		logic [18:0] distance;
		logic        last;
		logic        count_overflow;
	} out_item_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_PICK   = 7'b0000100,
		ST_SQRT   = 7'b0001000,
		ST_EMIT   = 7'b0010000,
		ST_CLEAR  = 7'b0100000,
		ST_WORST  = 7'b1000000
	} state_t;

	// One slot of the neighbor list as it moves through the chain.
	typedef struct packed {
		logic [DIST_BITS-1:0] sqd;
		logic [15:0]          idx;
		logic                 valid;
		logic                 used;
	} slot_t;

endpackage

// ----- src/knn_brute_force_select.sv -----
// Top level: distance accumulation, MAX_K-slot chain of cells and sorted emission.
//  channel  | ports                          | handshake
//  input    | start, busy, in_item           | taken when start && !busy
//  config   | cfg_we, cfg_index, cfg_data    | taken when cfg_we
//  result   | result_valid, result           | one-cycle strobe, no stall
// A query or training coordinate is taken while idle; a completed point
// that enters the list, or a write of k, adds a worst-slot scan as the
// chain rotates once. Finish, per result, rotates the chain once to find
// the next slot, rotates that slot to the head and runs the square root,
// then clears the list and the counters.
// Reset clears the list at once; the receiver cannot stall results.
module knn_brute_force_select (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  knn_pkg::in_item_t in_item,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [4:0]        cfg_data,
	output logic              result_valid,
	output knn_pkg::out_item_t result
);
	localparam int MAX_DIMS = knn_pkg::MAX_DIMS;
	localparam int MAX_K = knn_pkg::MAX_K;
	localparam int DB = knn_pkg::DIST_BITS;
	localparam int KB = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int DIB = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CB = 18;
	localparam logic [CB-1:0] COUNT_SAT = CB'(65537);

	logic [4:0] dims_q, k_q;
	logic [5:0] dims_eff, k_eff;
	logic signed [15:0] query_q [MAX_DIMS];
	logic [4:0] qpos_q, cpos_q;
	logic [DB-1:0] sum_q;
	logic [CB-1:0] count_q;
	logic [KB-1:0] worst_q, rot_q;
	logic [DB-1:0] worst_d_q;
	knn_pkg::state_t st_q;
	logic [KB:0] step_q;
	logic [4:0] emit_n_q;

	// chain
	knn_pkg::slot_t slots [MAX_K];
	logic shift, clear, load, mark;
	knn_pkg::slot_t load_val;
	logic [KB-1:0] best_q;
	logic have_q;
	knn_pkg::slot_t best_s_q;
	logic [DB-1:0] scan_d_q;
	logic [KB-1:0] scan_p_q;

	assign dims_eff = (dims_q == 5'd0) ? 6'd1 :
		({1'b0, dims_q} > 6'(MAX_DIMS)) ? 6'(MAX_DIMS) : {1'b0, dims_q};
	assign k_eff = (k_q == 5'd0) ? 6'd1 :
		({1'b0, k_q} > 6'(MAX_K)) ? 6'(MAX_K) : {1'b0, k_q};

	// head slot (0) is the one at logical position rot_q
	logic [KB-1:0] head_log;
	assign head_log = rot_q;
	logic in_k;
	assign in_k = {1'b0, head_log} < k_eff[KB:0];

	assign busy = (st_q != knn_pkg::ST_IDLE);

	// training arithmetic
	logic [4:0] cp;
	logic signed [16:0] diff;
	logic [16:0] mag;
	logic [33:0] sq;
	logic [DB:0] nsum;
	logic [DB-1:0] sum_new;
	logic accept;
	assign accept = start && !busy;
	assign cp = ({1'b0, cpos_q} >= 6'(MAX_DIMS)) ? 5'd0 : cpos_q;
	assign diff = 17'(in_item.coordinate) - 17'(query_q[cp[DIB-1:0]]);
	assign mag = diff[16] ? 17'(-diff) : 17'(diff);
	assign sq = 34'(mag) * 34'(mag);
	assign nsum = {1'b0, sum_q} + (DB+1)'(sq);
	assign sum_new = (nsum > (DB+1)'(knn_pkg::DIST_MAXFIN)) ?
		knn_pkg::DIST_MAXFIN : nsum[DB-1:0];

	logic replace_q;
	logic [DB-1:0] rep_d_q;
	logic [15:0] rep_i_q;

	logic sq_go, sq_done;
	logic [knn_pkg::ROOT_BITS-1:0] root;
	knn_sqrt u_sqrt (.clk, .arst_n, .go(sq_go), .x(best_s_q.sqd),
		.done(sq_done), .root);

	// rotation: slot j takes slot j+1 so the head advances logically;
	// a new entry enters at the tail, where the old head slot lands
	genvar g;
	generate
		for (g = 0; g < MAX_K; g++) begin : g_cell
			knn_cell u_cell (.clk, .arst_n, .shift, .clear,
				.load(load && g == MAX_K - 1), .load_val,
				.mark(mark && g == 0),
				.prev(slots[(g + 1) % MAX_K]), .slot(slots[g]));
		end
	endgenerate

	always_comb begin
		shift = 1'b0;
		clear = 1'b0;
		load = 1'b0;
		mark = 1'b0;
		load_val = '{sqd: rep_d_q, idx: rep_i_q, valid: 1'b1, used: 1'b0};
		sq_go = 1'b0;
		case (st_q)
			knn_pkg::ST_WORST: begin
				shift = 1'b1;
				load = replace_q && (head_log == worst_q);
			end
			knn_pkg::ST_SCAN: shift = 1'b1;
			knn_pkg::ST_PICK: begin
				shift = (head_log != best_q);
				mark = (head_log == best_q);
				sq_go = (head_log == best_q);
			end
			knn_pkg::ST_CLEAR: clear = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 5'd16;
			k_q <= 5'd4;
			for (int i = 0; i < MAX_DIMS; i++) query_q[i] <= '0;
			qpos_q <= '0;
			cpos_q <= '0;
			sum_q <= '0;
			count_q <= '0;
			worst_q <= '0;
			worst_d_q <= knn_pkg::DIST_ONES;
			rot_q <= '0;
			st_q <= knn_pkg::ST_IDLE;
			step_q <= '0;
			emit_n_q <= '0;
			replace_q <= 1'b0;
			rep_d_q <= '0;
			rep_i_q <= '0;
			best_q <= '0;
			have_q <= 1'b0;
			best_s_q <= '0;
			scan_d_q <= '0;
			scan_p_q <= '0;
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == knn_pkg::REG_DIMS) dims_q <= cfg_data;
				else begin
					k_q <= cfg_data;
					replace_q <= 1'b0;
					have_q <= 1'b0;
					st_q <= knn_pkg::ST_WORST;
					step_q <= '0;
				end
			end
			if (shift) rot_q <= (rot_q == KB'(MAX_K - 1)) ? '0 : rot_q + 1'b1;
			case (st_q)
				knn_pkg::ST_IDLE: begin
					if (accept) begin
						if (in_item.kind == knn_pkg::KIND_QUERY) begin
							logic [4:0] p;
							p = ({1'b0, qpos_q} >= 6'(MAX_DIMS)) ? 5'd0 : qpos_q;
							query_q[p[DIB-1:0]] <= in_item.coordinate;
							qpos_q <= ({1'b0, p} + 6'd1 >= dims_eff) ? 5'd0 : p + 5'd1;
						end else if (in_item.kind == knn_pkg::KIND_TRAIN) begin
							if ({1'b0, cp} + 6'd1 >= dims_eff) begin
								if (sum_new < worst_d_q) begin
									replace_q <= 1'b1;
									rep_d_q <= sum_new;
									rep_i_q <= count_q[15:0];
									have_q <= 1'b0;
									st_q <= knn_pkg::ST_WORST;
									step_q <= '0;
								end
								if (count_q < COUNT_SAT) count_q <= count_q + 1'b1;
								sum_q <= '0;
								cpos_q <= '0;
							end else begin
								sum_q <= sum_new;
								cpos_q <= cp + 5'd1;
							end
						end else if (in_item.kind == knn_pkg::KIND_FINISH) begin
							emit_n_q <= '0;
							st_q <= knn_pkg::ST_SCAN;
							step_q <= '0;
							have_q <= 1'b0;
						end
					end
				end
				knn_pkg::ST_WORST: begin
					// head slot at logical head_log, after optional load;
					// largest wins, lower slot on ties
					logic [DB-1:0] d;
					logic take;
					d = (load) ? rep_d_q : slots[0].sqd;
					take = in_k && (!have_q || d > scan_d_q ||
						(d == scan_d_q && head_log < scan_p_q));
					if (take) begin
						have_q <= 1'b1;
						scan_d_q <= d;
						scan_p_q <= head_log;
					end
					step_q <= step_q + 1'b1;
					if (step_q == (KB+1)'(MAX_K - 1)) begin
						replace_q <= 1'b0;
						worst_q <= take ? head_log : scan_p_q;
						worst_d_q <= take ? d : scan_d_q;
						st_q <= knn_pkg::ST_IDLE;
					end
				end
				knn_pkg::ST_SCAN: begin
					if (in_k && !slots[0].used &&
						(!have_q || slots[0].sqd < best_s_q.sqd ||
						(slots[0].sqd == best_s_q.sqd && head_log < best_q))) begin
						have_q <= 1'b1;
						best_q <= head_log;
						best_s_q <= slots[0];
					end
					step_q <= step_q + 1'b1;
					if (step_q == (KB+1)'(MAX_K - 1)) st_q <= knn_pkg::ST_PICK;
				end
				knn_pkg::ST_PICK: begin
					if (head_log == best_q) st_q <= knn_pkg::ST_SQRT;
				end
				knn_pkg::ST_SQRT: begin
					if (sq_done) begin
						result_valid <= 1'b1;
						result.neighbour_index <= best_s_q.valid ? best_s_q.idx : 16'd0;
						result.neighbour_valid <= best_s_q.valid;
						result.distance <= best_s_q.valid ? root : 19'h7FFFF;
						result.last <= ({1'b0, emit_n_q} + 6'd1 == k_eff);
						result.count_overflow <= (count_q > CB'(65536));
						if ({1'b0, emit_n_q} + 6'd1 == k_eff) begin
							st_q <= knn_pkg::ST_CLEAR;
						end else begin
							emit_n_q <= emit_n_q + 5'd1;
							have_q <= 1'b0;
							step_q <= '0;
							st_q <= knn_pkg::ST_SCAN;
						end
					end
				end
				knn_pkg::ST_CLEAR: begin
					count_q <= '0;
					cpos_q <= '0;
					sum_q <= '0;
					qpos_q <= '0;
					worst_q <= '0;
					worst_d_q <= knn_pkg::DIST_ONES;
					st_q <= knn_pkg::ST_IDLE;
				end
				default: st_q <= knn_pkg::ST_IDLE;
			endcase
		end
	end
endmodule

// ----- src/knn_cell.sv -----
// One list cell: holds a slot, takes its neighbor's slot on shift, and clears, loads or marks it used on command.
module knn_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  logic           clear,
	input  logic           load,
	input  knn_pkg::slot_t load_val,
	input  logic           mark,
	input  knn_pkg::slot_t prev,
	output knn_pkg::slot_t slot
);
	knn_pkg::slot_t slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '{sqd: knn_pkg::DIST_ONES, idx: '0, valid: 1'b0, used: 1'b0};
		end else if (clear) begin
			slot_q <= '{sqd: knn_pkg::DIST_ONES, idx: '0, valid: 1'b0, used: 1'b0};
		end else if (load) begin
			slot_q <= load_val;
		end else if (shift) begin
			slot_q <= prev;
		end else if (mark) begin
			slot_q.used <= 1'b1;
		end
	end

	assign slot = slot_q;
endmodule

// ----- src/knn_sqrt.sv -----
// Bit-serial integer square root, one result bit resolved per cycle.
module knn_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [knn_pkg::DIST_BITS-1:0] x,
	output logic                          done,
	output logic [knn_pkg::ROOT_BITS-1:0] root
);
	localparam int W = knn_pkg::DIST_BITS + 2;
	logic [W-1:0] rem_q, r_q, bit_q;
	logic         busy_q;
	logic [W-1:0] t;

	assign t = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			rem_q  <= '0;
			r_q    <= '0;
			bit_q  <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				rem_q  <= {2'b00, x};
				r_q    <= '0;
				bit_q  <= {2'b01, {(W-2){1'b0}}};
			end else if (busy_q) begin
				if (rem_q >= t) begin
					rem_q <= rem_q - t;
					r_q   <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[1:0] != 2'b00) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign root = r_q[knn_pkg::ROOT_BITS-1:0];
endmodule
